>>> rtl/lnes_pkg.sv
// ----------------------------------------------------------------------------
// lnes_pkg
// Shared types and constants for the looping note event sequencer.
// ----------------------------------------------------------------------------
package lnes_pkg;

   localparam int MAX_NOTES = 32;
   localparam int SLOT_W    = 5;
   localparam int CNT_W     = 6;
   localparam int TICK_W    = 21;
   localparam int FRAC_W    = 24;
   localparam int RATE_W    = 32;
   localparam int LEN_W     = 20;
   localparam int FRAMES_W  = 16;
   localparam int SPAN_W    = RATE_W + FRAMES_W;
   localparam int TOTAL_W   = SPAN_W + 1;
   localparam int WHOLE_W   = TOTAL_W - FRAC_W;
   localparam int DIV_W     = WHOLE_W + 1;
   localparam int WIN_W     = DIV_W;
   localparam int DCNT_W    = 5;
   localparam int KEY_W     = 7;
   localparam int VEL_W     = 7;
   localparam int CHAN_W    = 4;
   localparam int MODE_W    = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PLAY    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PAUSE   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_STOP    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ADVANCE = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_TICK_RATE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NOTE_COUNT     = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_OFS,
      ST_READ,
      ST_CMP,
      ST_EMIT,
      ST_FLUSH,
      ST_DIV_POS
   } state_type;

   typedef struct packed {
      logic [TICK_W-1:0] start_tick;
      logic [TICK_W-1:0] end_tick;
      logic [KEY_W-1:0]  key;
      logic [VEL_W-1:0]  velocity;
      logic [CHAN_W-1:0] channel;
   } note_type;

   typedef struct packed {
      logic accept;
      logic mul;
      logic div_ofs_start;
      logic prep;
      logic ofs_load;
      logic rd;
      logic cmp;
      logic push_on;
      logic push_off;
      logic next_note;
      logic flush;
      logic div_pos_start;
      logic pos_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic adv_go;
      logic div_done;
      logic out_free;
      logic pend_valid;
      logic hit_on;
      logic hit_off;
      logic last_note;
   } dp_status_type;

endpackage

>>> rtl/lnes_if.sv
// ----------------------------------------------------------------------------
// lnes_if
// Channel interfaces: item requests, event responses and register writes.
// ----------------------------------------------------------------------------
interface lnes_req_if import lnes_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [FRAMES_W-1:0] frames;
   logic [SLOT_W-1:0]   entry_index;
   logic [TICK_W-1:0]   start_tick;
   logic [TICK_W-1:0]   end_tick;
   logic [KEY_W-1:0]    note_key;
   logic [VEL_W-1:0]    note_velocity;
   logic [CHAN_W-1:0]   note_channel;

   modport source (output valid, mode, frames, entry_index, start_tick, end_tick,
                   note_key, note_velocity, note_channel, input ready);
   modport sink (input valid, mode, frames, entry_index, start_tick, end_tick,
                 note_key, note_velocity, note_channel, output ready);
endinterface

interface lnes_rsp_if import lnes_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              is_note_off;
   logic [KEY_W-1:0]  event_key;
   logic [VEL_W-1:0]  event_velocity;
   logic [CHAN_W-1:0] event_channel;
   logic [SLOT_W-1:0] event_slot;
   logic              last_event;

   modport source (output valid, is_note_off, event_key, event_velocity,
                   event_channel, event_slot, last_event, input ready);
   modport sink (input valid, is_note_off, event_key, event_velocity,
                 event_channel, event_slot, last_event, output ready);
endinterface

interface lnes_csr_if import lnes_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/lnes_div.sv
// ----------------------------------------------------------------------------
// lnes_div
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lnes_div import lnes_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [LEN_W-1:0] divisor,
   output logic             done,
   output logic [LEN_W-1:0] remainder
);

   logic [DIV_W-1:0]  dvd_ff;
   logic [LEN_W-1:0]  rem_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [LEN_W:0]    trial;
   logic [LEN_W:0]    diff;

   assign trial = {rem_ff, dvd_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= DCNT_W'(DIV_W - 1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_ff <= diff[LEN_W-1:0];
         end else begin
            rem_ff <= trial[LEN_W-1:0];
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/lnes_ctrl.sv
// ----------------------------------------------------------------------------
// lnes_ctrl
// Sequencer state machine: transport handling, advance scan and event flow.
// ----------------------------------------------------------------------------
module lnes_ctrl import lnes_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;
   logic      can_push;

   assign can_push = !status.pend_valid || status.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && status.adv_go) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul           = 1'b1;
            cmd.div_ofs_start = 1'b1;
            state_in          = ST_DIV_OFS;
         end
         ST_DIV_OFS: begin
            cmd.prep = 1'b1;
            if (status.div_done) begin
               cmd.ofs_load = 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            priority if (status.hit_on) begin
               cmd.push_on = can_push;
            end else if (status.hit_off) begin
               cmd.push_off = can_push;
            end else begin
               cmd.next_note = 1'b1;
               state_in      = status.last_note ? ST_FLUSH : ST_READ;
            end
         end
         ST_FLUSH: begin
            priority if (!status.pend_valid) begin
               cmd.div_pos_start = 1'b1;
               state_in          = ST_DIV_POS;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
            end
         end
         ST_DIV_POS: begin
            if (status.div_done) begin
               cmd.pos_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/lnes_dp.sv
// ----------------------------------------------------------------------------
// lnes_dp
// Datapath: registers, note table, span math, window compare, event output.
// ----------------------------------------------------------------------------
module lnes_dp import lnes_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        status,
   input  logic [MODE_W-1:0]    req_mode,
   input  logic [FRAMES_W-1:0]  req_frames,
   input  logic [SLOT_W-1:0]    req_entry_index,
   input  logic [TICK_W-1:0]    req_start_tick,
   input  logic [TICK_W-1:0]    req_end_tick,
   input  logic [KEY_W-1:0]     req_note_key,
   input  logic [VEL_W-1:0]     req_note_velocity,
   input  logic [CHAN_W-1:0]    req_note_channel,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   lnes_rsp_if.source           rsp_ch
);

   localparam logic [TOTAL_W-1:0] ROUND_UP = TOTAL_W'((64'd1 << FRAC_W) - 64'd1);

   logic [RATE_W-1:0]   rate_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [CNT_W-1:0]    ncnt_ff;
   logic                playing_ff;
   logic [LEN_W-1:0]    pos_ff;
   logic [FRAC_W-1:0]   frac_ff;
   logic [FRAMES_W-1:0] frames_ff;
   logic [SPAN_W-1:0]   span_ff;
   logic [WIN_W-1:0]    win_hi_ff;
   logic [TOTAL_W-1:0]  total_ff;
   logic [LEN_W-1:0]    offset_ff;
   logic [SLOT_W-1:0]   index_ff;
   note_type            mem [MAX_NOTES];
   note_type            mem_q;
   logic                hit_on_ff;
   logic                hit_off_ff;
   logic                pend_valid_ff;
   logic                pend_off_ff;
   logic [SLOT_W-1:0]   pend_slot_ff;
   logic [KEY_W-1:0]    pend_key_ff;
   logic [VEL_W-1:0]    pend_vel_ff;
   logic [CHAN_W-1:0]   pend_chan_ff;
   logic                out_valid_ff;
   logic                out_off_ff;
   logic [SLOT_W-1:0]   out_slot_ff;
   logic [KEY_W-1:0]    out_key_ff;
   logic [VEL_W-1:0]    out_vel_ff;
   logic [CHAN_W-1:0]   out_chan_ff;
   logic                out_last_ff;

   logic [CNT_W-1:0]    count;
   logic [SLOT_W-1:0]   last_slot;
   logic [TOTAL_W-1:0]  ceil_sum;
   logic [WIN_W-1:0]    win_lo;
   logic [WIN_W-1:0]    s_abs;
   logic [WIN_W-1:0]    e_abs;
   logic                push;
   logic                out_load;
   logic                div_start;
   logic [DIV_W-1:0]    div_dividend;
   logic                div_done;
   logic [LEN_W-1:0]    div_rem;

   assign count     = (ncnt_ff > CNT_W'(MAX_NOTES)) ? CNT_W'(MAX_NOTES) : ncnt_ff;
   assign last_slot = SLOT_W'(count - 1'b1);
   assign ceil_sum  = TOTAL_W'(span_ff) + ROUND_UP;
   assign win_lo    = WIN_W'(pos_ff);
   assign s_abs     = WIN_W'(mem_q.start_tick) + WIN_W'(offset_ff);
   assign e_abs     = WIN_W'(mem_q.end_tick) + WIN_W'(offset_ff);
   assign push      = cmd.push_on || cmd.push_off;
   assign out_load  = (push && pend_valid_ff) || cmd.flush;

   assign div_start    = cmd.div_ofs_start || cmd.div_pos_start;
   assign div_dividend = cmd.div_pos_start
                       ? DIV_W'(pos_ff) + DIV_W'(total_ff[TOTAL_W-1:FRAC_W])
                       : DIV_W'(pos_ff);

   lnes_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (len_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= '0;
         len_ff  <= '0;
         ncnt_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == REG_TICK_RATE) begin
            rate_ff <= csr_data[RATE_W-1:0];
         end
         if (csr_index == REG_PATTERN_LENGTH) begin
            len_ff <= csr_data[LEN_W-1:0];
         end
         if (csr_index == REG_NOTE_COUNT) begin
            ncnt_ff <= csr_data[CNT_W-1:0];
         end
      end
   end

   // transport and play position
   always_ff @(posedge clock) begin
      if (reset) begin
         playing_ff <= 1'b0;
         pos_ff     <= '0;
         frac_ff    <= '0;
      end else if (cmd.accept && (req_mode == MODE_PLAY)) begin
         playing_ff <= 1'b1;
      end else if (cmd.accept && (req_mode == MODE_PAUSE)) begin
         playing_ff <= 1'b0;
      end else if (cmd.accept && (req_mode == MODE_STOP)) begin
         playing_ff <= 1'b0;
         pos_ff     <= '0;
         frac_ff    <= '0;
      end else if (cmd.pos_load) begin
         pos_ff  <= div_rem;
         frac_ff <= total_ff[FRAC_W-1:0];
      end
   end

   // note table
   always_ff @(posedge clock) begin
      if (cmd.accept && (req_mode == MODE_WRITE)) begin
         mem[req_entry_index] <= '{start_tick: req_start_tick, end_tick: req_end_tick,
                                   key: req_note_key, velocity: req_note_velocity,
                                   channel: req_note_channel};
      end
      if (cmd.rd) begin
         mem_q <= mem[index_ff];
      end
   end

   // span, window and scan
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         frames_ff <= req_frames;
      end
      if (cmd.mul) begin
         span_ff <= SPAN_W'(rate_ff) * SPAN_W'(frames_ff);
      end
      if (cmd.prep) begin
         win_hi_ff <= win_lo + WIN_W'(ceil_sum[TOTAL_W-1:FRAC_W]);
         total_ff  <= TOTAL_W'(frac_ff) + TOTAL_W'(span_ff);
      end
      if (cmd.ofs_load) begin
         offset_ff <= pos_ff - div_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff   <= '0;
         hit_on_ff  <= 1'b0;
         hit_off_ff <= 1'b0;
      end else begin
         if (cmd.ofs_load) begin
            index_ff <= '0;
         end else if (cmd.next_note) begin
            index_ff <= index_ff + 1'b1;
         end
         if (cmd.cmp) begin
            hit_on_ff  <= (s_abs >= win_lo) && (s_abs < win_hi_ff);
            hit_off_ff <= (e_abs >= win_lo) && (e_abs < win_hi_ff);
         end else begin
            if (cmd.push_on) begin
               hit_on_ff <= 1'b0;
            end
            if (cmd.push_off) begin
               hit_off_ff <= 1'b0;
            end
         end
      end
   end

   // one-event lookahead so the final event can carry last_event
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (push) begin
         pend_valid_ff <= 1'b1;
      end else if (cmd.flush) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         pend_off_ff  <= cmd.push_off;
         pend_slot_ff <= index_ff;
         pend_key_ff  <= mem_q.key;
         pend_vel_ff  <= mem_q.velocity;
         pend_chan_ff <= mem_q.channel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_off_ff  <= pend_off_ff;
         out_slot_ff <= pend_slot_ff;
         out_key_ff  <= pend_key_ff;
         out_vel_ff  <= pend_vel_ff;
         out_chan_ff <= pend_chan_ff;
         out_last_ff <= cmd.flush;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.is_note_off    = out_off_ff;
   assign rsp_ch.event_key      = out_key_ff;
   assign rsp_ch.event_velocity = out_vel_ff;
   assign rsp_ch.event_channel  = out_chan_ff;
   assign rsp_ch.event_slot     = out_slot_ff;
   assign rsp_ch.last_event     = out_last_ff;

   assign status.adv_go     = (req_mode == MODE_ADVANCE) && playing_ff
                            && (req_frames != '0) && (count != '0) && (len_ff != '0);
   assign status.div_done   = div_done;
   assign status.out_free   = !out_valid_ff || rsp_ch.ready;
   assign status.pend_valid = pend_valid_ff;
   assign status.hit_on     = hit_on_ff;
   assign status.hit_off    = hit_off_ff;
   assign status.last_note  = (index_ff == last_slot);

endmodule

>>> rtl/looping_note_event_sequencer_unit.sv
// ----------------------------------------------------------------------------
// looping_note_event_sequencer_unit
// Looping note pattern player that turns audio buffer advances into events.
// ----------------------------------------------------------------------------
// Write, play, pause and stop transactions are taken in the idle state. An
// advance that plays runs longer, and longer still while the response side
// stalls: the bit-serial remainder unit runs twice (loop offset, then the
// wrapped position), and the note table is scanned one slot per
// read-compare-decide step through its single read port. The last event of
// an advance is marked with last_event. Register writes are taken in any
// cycle and must be made while the block is idle.
// ----------------------------------------------------------------------------
module looping_note_event_sequencer_unit import lnes_pkg::*; (
   input logic        clock,
   input logic        reset,
   lnes_req_if.sink   req_ch,
   lnes_rsp_if.source rsp_ch,
   lnes_csr_if.sink   csr_ch
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          req_ready;

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   lnes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lnes_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mode          (req_ch.mode),
      .req_frames        (req_ch.frames),
      .req_entry_index   (req_ch.entry_index),
      .req_start_tick    (req_ch.start_tick),
      .req_end_tick      (req_ch.end_tick),
      .req_note_key      (req_ch.note_key),
      .req_note_velocity (req_ch.note_velocity),
      .req_note_channel  (req_ch.note_channel),
      .csr_valid         (csr_ch.valid),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data),
      .rsp_ch            (rsp_ch)
   );

endmodule

>>> rtl/lnes_checker.sv
// ----------------------------------------------------------------------------
// lnes_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lnes_checker import lnes_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_last,
   input logic              rsp_off,
   input logic [SLOT_W-1:0] rsp_slot
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("event dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_slot) && $stable(rsp_off)
                                  && $stable(rsp_last))
      else $error("event payload changed while stalled");

   a_no_event_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_ready)
      else $error("event appeared while idle");

   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_last)
      else $error("non-final event left over after advance");

endmodule

bind looping_note_event_sequencer_unit lnes_checker u_lnes_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_last  (rsp_ch.last_event),
   .rsp_off   (rsp_ch.is_note_off),
   .rsp_slot  (rsp_ch.event_slot)
);
